/* hdl/bmm_pkg.sv */
`timescale 1ns / 1ps

package bmm_pkg;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [2:0]  CFG_ADDR_VARIANT = 3'd0;

    localparam logic [23:0] ADDR_PLAYER = 24'h300000;
    localparam logic [23:0] ADDR_COIN   = 24'h400000;
    localparam logic [23:0] ADDR_LATCH  = 24'h600000;
    localparam logic [23:0] ADDR_SCROLL = 24'h700000;
    localparam logic [23:0] ADDR_SOUND  = 24'ha00000;

    localparam logic [15:0] PROT_OFF_FOUR  = 16'h9e98;
    localparam logic [15:0] PROT_OFF_ZLO   = 16'h9e99;
    localparam logic [15:0] PROT_OFF_ZHI   = 16'h9e9b;
    localparam logic [15:0] PROT_VAL_FOUR  = 16'd4;
    localparam logic [15:0] UNMAPPED_WORD  = 16'hffff;
    localparam logic [8:0]  SCROLL_MASK    = 9'h1ff;

    localparam int WORK_DEPTH   = 32768;
    localparam int SPRITE_DEPTH = 2048;
    localparam int PAL_DEPTH    = 8192;
    localparam int TILE_DEPTH   = 16384;

    // floor(v * 255 / 31) for a 5-bit channel
    localparam logic [7:0] SCALE5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    typedef enum logic [3:0] {
        RGN_NONE,
        RGN_ROM,
        RGN_WORK,
        RGN_PLAYER,
        RGN_COIN,
        RGN_SPRITE,
        RGN_LATCH,
        RGN_SCROLL,
        RGN_PAL,
        RGN_TILE,
        RGN_SOUND
    } region_t;

    typedef enum logic [2:0] {
        SRC_FIXED,
        SRC_WORK,
        SRC_SPRITE,
        SRC_PAL,
        SRC_TILE
    } rd_src_t;

    typedef struct packed {
        region_t     region;
        logic        prot_hit;
        logic [15:0] prot_val;
    } decode_t;

    typedef struct packed {
        logic        req_type;
        logic [23:0] address;
        logic [15:0] write_data;
        logic [15:0] rom_word;
        logic        eeprom_data_out;
        logic [7:0]  sound_status;
        logic [15:0] player_word;
        logic [3:0]  coin_nibble;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        eeprom_strobe;
        logic        eeprom_di;
        logic        eeprom_cs;
        logic        eeprom_clk;
        logic        sound_bank;
        logic        sound_write_strobe;
        logic [7:0]  sound_write_byte;
        logic [8:0]  scroll_value;
    } rsp_t;

    function automatic logic [23:0] rgb_of(input logic [15:0] v);
        rgb_of = {SCALE5_LUT[v[14:10]], SCALE5_LUT[v[9:5]], SCALE5_LUT[v[4:0]]};
    endfunction

endpackage

/* hdl/bmm_ram.sv */
`timescale 1ns / 1ps

module bmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

/* hdl/bmm_decode.sv */
`timescale 1ns / 1ps

module bmm_decode (
    input  logic [23:0]      address,
    input  logic             variant,
    output bmm_pkg::decode_t dec
);

    import bmm_pkg::*;

    logic [15:0] off;

    assign off = address[15:0];

    always_comb
    begin
        dec.region   = RGN_NONE;
        dec.prot_hit = 1'b0;
        dec.prot_val = '0;
        if (address[23:20] == 4'h0)
        begin
            dec.region = RGN_ROM;
        end
        else if (address[23:16] == 8'h10)
        begin
            dec.region = RGN_WORK;
        end
        else if (address == ADDR_PLAYER)
        begin
            dec.region = RGN_PLAYER;
        end
        else if (address == ADDR_COIN)
        begin
            dec.region = RGN_COIN;
        end
        else if (address[23:12] == 12'h500)
        begin
            dec.region = RGN_SPRITE;
        end
        else if (address == ADDR_LATCH)
        begin
            dec.region = RGN_LATCH;
        end
        else if (address == ADDR_SCROLL)
        begin
            dec.region = RGN_SCROLL;
        end
        else if (address[23:14] == 10'h200)
        begin
            dec.region = RGN_PAL;
        end
        else if (address[23:15] == 9'h120)
        begin
            dec.region = RGN_TILE;
        end
        else if (address == ADDR_SOUND)
        begin
            dec.region = RGN_SOUND;
        end

        // protection words only exist on the second game
        if (variant && dec.region == RGN_WORK)
        begin
            if (off == PROT_OFF_FOUR)
            begin
                dec.prot_hit = 1'b1;
                dec.prot_val = PROT_VAL_FOUR;
            end
            else if (off inside {[PROT_OFF_ZLO:PROT_OFF_ZHI]})
            begin
                dec.prot_hit = 1'b1;
            end
        end
    end

endmodule

/* hdl/board_memory_map_bus.sv */
`timescale 1ns / 1ps
// channel   | signals                                      | request taken when
// ----------+----------------------------------------------+--------------------------------
// request   | start, busy, req (bmm_pkg::req_t)            | start && !busy at clk rise
// result    | done, rsp (bmm_pkg::rsp_t)                   | done high, one cycle, no stall
// config    | psel, penable, pwrite, paddr, pwdata, prdata | psel && penable && pwrite
//
// One request per cycle; busy stays low. The result shows in the cycle after
// the request is taken: the RAMs register their read data at the accept edge.
// Writes land in the RAM at the accept edge, so a read in the next cycle sees them.
// rst_n clears latches, the variant register and done; RAM contents are not cleared.
// The receiver cannot stall; a result not sampled in its cycle is gone.

module board_memory_map_bus (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bmm_pkg::req_t  req,
    output logic           done,
    output bmm_pkg::rsp_t  rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    import bmm_pkg::*;

    logic        accept;
    logic        is_wr;
    decode_t     dec;

    logic        variant_reg;
    logic        done_reg, done_next;
    rd_src_t     src_reg, src_next;
    logic [15:0] fixed_reg, fixed_next;
    logic        ee_strobe_reg, ee_strobe_next;
    logic        snd_strobe_reg, snd_strobe_next;
    logic [7:0]  snd_byte_reg, snd_byte_next;
    logic [8:0]  scroll_reg, scroll_next;
    logic        bank_reg, bank_next;
    logic [2:0]  pins_reg, pins_next;

    logic [15:0] work_rd, sprite_rd, pal_rd, tile_rd;
    logic [15:0] rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign is_wr  = (req.req_type == REQ_WRITE);
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == CFG_ADDR_VARIANT)
        begin
            prdata = {31'b0, variant_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr == CFG_ADDR_VARIANT)
        begin
            variant_reg <= pwdata[0];
        end
    end

    bmm_decode u_decode (
        .address (req.address),
        .variant (variant_reg),
        .dec     (dec)
    );

    bmm_ram #(.WIDTH(16), .DEPTH(WORK_DEPTH)) u_work_ram (
        .clk   (clk),
        .en    (accept),
        .we    (is_wr && dec.region == RGN_WORK),
        .addr  (req.address[15:1]),
        .wdata (req.write_data),
        .rdata (work_rd)
    );

    bmm_ram #(.WIDTH(16), .DEPTH(SPRITE_DEPTH)) u_sprite_ram (
        .clk   (clk),
        .en    (accept),
        .we    (is_wr && dec.region == RGN_SPRITE),
        .addr  (req.address[11:1]),
        .wdata (req.write_data),
        .rdata (sprite_rd)
    );

    bmm_ram #(.WIDTH(16), .DEPTH(PAL_DEPTH)) u_pal_ram (
        .clk   (clk),
        .en    (accept),
        .we    (is_wr && dec.region == RGN_PAL),
        .addr  (req.address[13:1]),
        .wdata (req.write_data),
        .rdata (pal_rd)
    );

    // colour store holds the RGB form of each palette write; nothing on this bus reads it
    bmm_ram #(.WIDTH(24), .DEPTH(PAL_DEPTH)) u_colour_ram (
        .clk   (clk),
        .en    (accept),
        .we    (is_wr && dec.region == RGN_PAL),
        .addr  (req.address[13:1]),
        .wdata (rgb_of(req.write_data)),
        .rdata ()
    );

    bmm_ram #(.WIDTH(16), .DEPTH(TILE_DEPTH)) u_tile_ram (
        .clk   (clk),
        .en    (accept),
        .we    (is_wr && dec.region == RGN_TILE),
        .addr  (req.address[14:1]),
        .wdata (req.write_data),
        .rdata (tile_rd)
    );

    always_comb
    begin
        done_next       = accept;
        src_next        = SRC_FIXED;
        fixed_next      = '0;
        ee_strobe_next  = 1'b0;
        snd_strobe_next = 1'b0;
        snd_byte_next   = '0;
        scroll_next     = scroll_reg;
        bank_next       = bank_reg;
        pins_next       = pins_reg;

        if (accept && !is_wr)
        begin
            case (dec.region)
                RGN_ROM:    fixed_next = req.rom_word;
                RGN_WORK:
                begin
                    if (dec.prot_hit)
                    begin
                        fixed_next = dec.prot_val;
                    end
                    else
                    begin
                        src_next = SRC_WORK;
                    end
                end
                RGN_PLAYER: fixed_next = req.player_word;
                RGN_COIN:   fixed_next = {11'b0, req.eeprom_data_out && !variant_reg,
                                          req.coin_nibble};
                RGN_SPRITE: src_next   = SRC_SPRITE;
                RGN_PAL:    src_next   = SRC_PAL;
                RGN_TILE:   src_next   = SRC_TILE;
                RGN_SOUND:  fixed_next = {8'b0, req.sound_status};
                default:    fixed_next = UNMAPPED_WORD;
            endcase
        end
        else if (accept)
        begin
            case (dec.region)
                RGN_LATCH:
                begin
                    pins_next      = req.write_data[2:0];
                    bank_next      = req.write_data[6];
                    ee_strobe_next = 1'b1;
                end
                RGN_SCROLL: scroll_next = req.write_data[8:0] & SCROLL_MASK;
                RGN_SOUND:
                begin
                    snd_strobe_next = 1'b1;
                    snd_byte_next   = req.write_data[7:0];
                end
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            ee_strobe_reg  <= 1'b0;
            snd_strobe_reg <= 1'b0;
            scroll_reg     <= '0;
            bank_reg       <= 1'b0;
            pins_reg       <= '0;
        end
        else
        begin
            done_reg       <= done_next;
            ee_strobe_reg  <= ee_strobe_next;
            snd_strobe_reg <= snd_strobe_next;
            scroll_reg     <= scroll_next;
            bank_reg       <= bank_next;
            pins_reg       <= pins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        fixed_reg    <= fixed_next;
        snd_byte_reg <= snd_byte_next;
    end

    always_comb
    begin
        case (src_reg)
            SRC_WORK:   rd_data = work_rd;
            SRC_SPRITE: rd_data = sprite_rd;
            SRC_PAL:    rd_data = pal_rd;
            SRC_TILE:   rd_data = tile_rd;
            default:    rd_data = fixed_reg;
        endcase
    end

    assign done                   = done_reg;
    assign rsp.read_data          = rd_data;
    assign rsp.eeprom_strobe      = ee_strobe_reg;
    assign rsp.eeprom_di          = pins_reg[2];
    assign rsp.eeprom_cs          = pins_reg[0];
    assign rsp.eeprom_clk         = pins_reg[1];
    assign rsp.sound_bank         = bank_reg;
    assign rsp.sound_write_strobe = snd_strobe_reg;
    assign rsp.sound_write_byte   = snd_byte_reg;
    assign rsp.scroll_value       = scroll_reg;

endmodule

/* hdl/bmm_checker.sv */
`timescale 1ns / 1ps

module bmm_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  bmm_pkg::req_t req,
    input  logic          done,
    input  bmm_pkg::rsp_t rsp
);

    import bmm_pkg::*;

    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("request taken but no result in the next cycle");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without a request");

    a_read_no_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type == REQ_READ) |=>
            (!rsp.eeprom_strobe && !rsp.sound_write_strobe))
        else $error("read request raised a write strobe");

    a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type == REQ_WRITE) |=> (rsp.read_data == 16'h0000))
        else $error("write request returned nonzero read data");

    a_sound_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.sound_write_strobe) |-> (rsp.sound_write_byte == 8'h00))
        else $error("sound byte nonzero without strobe");

endmodule

bind board_memory_map_bus bmm_checker u_bmm_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import bmm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    req_t        req = '0;
    logic        done;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    board_memory_map_bus i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // bus map shadow: RAM words keyed by region and word index, plus latches
    logic [15:0] ram_img [int];
    logic [23:0] ram_addrs [$];
    logic        model_variant = 1'b0;
    logic [2:0]  ee_pins = 3'b000;
    logic        bank_sel = 1'b0;
    logic [8:0]  scroll_reg = 9'h000;

    rsp_t        bus_results_due [$];
    rsp_t        want_rsp;
    int          n_errors = 0;
    bit          no_gaps = 1'b0;

    // directed rows; ext feeds rom_word, player_word, sound_status, coin and DO pin
    typedef struct packed {
        logic        variant;
        logic        rt;
        logic [23:0] addr;
        logic [15:0] wdata;
        logic [15:0] ext;
        logic        lit_ok;
        logic [15:0] lit;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{1'b0, REQ_READ,  24'h000000, 16'h0000, 16'h1234, 1'b1, 16'h1234},
        '{1'b0, REQ_READ,  24'h0fffff, 16'h0000, 16'hffff, 1'b1, 16'hffff},
        '{1'b0, REQ_READ,  ADDR_PLAYER, 16'h0000, 16'ha5a5, 1'b1, 16'ha5a5},
        '{1'b0, REQ_READ,  ADDR_COIN,  16'h0000, 16'h0015, 1'b1, 16'h0015},
        '{1'b0, REQ_READ,  ADDR_SOUND, 16'h0000, 16'h00c3, 1'b1, 16'h00c3},
        '{1'b0, REQ_READ,  ADDR_LATCH, 16'h0000, 16'h0000, 1'b1, 16'hffff},
        '{1'b0, REQ_READ,  ADDR_SCROLL, 16'h0000, 16'h0000, 1'b1, 16'hffff},
        '{1'b0, REQ_READ,  24'hffffff, 16'h0000, 16'h0000, 1'b1, 16'hffff},
        '{1'b0, REQ_WRITE, ADDR_LATCH, 16'hffff, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, REQ_WRITE, ADDR_LATCH, 16'h0000, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, REQ_WRITE, ADDR_SCROLL, 16'hffff, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, REQ_WRITE, ADDR_SOUND, 16'habcd, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, REQ_WRITE, 24'h109e98, 16'h8001, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, REQ_READ,  24'h109e99, 16'h0000, 16'h0000, 1'b1, 16'h8001},
        '{1'b0, REQ_WRITE, 24'h500fff, 16'h7fff, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, REQ_READ,  24'h500ffe, 16'h0000, 16'h0000, 1'b1, 16'h7fff},
        '{1'b0, REQ_WRITE, 24'h803ffe, 16'h7c1f, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, REQ_READ,  24'h803fff, 16'h0000, 16'h0000, 1'b1, 16'h7c1f},
        '{1'b0, REQ_WRITE, 24'h907ffe, 16'h1234, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, REQ_READ,  24'h907fff, 16'h0000, 16'h0000, 1'b1, 16'h1234},
        '{1'b0, REQ_READ,  24'h110000, 16'h0000, 16'h0000, 1'b1, 16'hffff},
        '{1'b0, REQ_READ,  24'h908000, 16'h0000, 16'h0000, 1'b1, 16'hffff},
        '{1'b0, REQ_WRITE, 24'h000010, 16'h5555, 16'h0000, 1'b1, 16'h0000},
        '{1'b1, REQ_READ,  ADDR_COIN,  16'h0000, 16'h0015, 1'b1, 16'h0005},
        '{1'b1, REQ_READ,  24'h109e98, 16'h0000, 16'h0000, 1'b1, PROT_VAL_FOUR},
        '{1'b1, REQ_READ,  24'h109e9b, 16'h0000, 16'h0000, 1'b1, 16'h0000}
    };

    function automatic region_t region_of(input logic [23:0] a);
        if (a <= 24'h0fffff)
            return RGN_ROM;
        if (a[23:16] == 8'h10)
            return RGN_WORK;
        if (a == ADDR_PLAYER)
            return RGN_PLAYER;
        if (a == ADDR_COIN)
            return RGN_COIN;
        if (a[23:12] == 12'h500)
            return RGN_SPRITE;
        if (a == ADDR_LATCH)
            return RGN_LATCH;
        if (a == ADDR_SCROLL)
            return RGN_SCROLL;
        if (a[23:14] == 10'h200)
            return RGN_PAL;
        if (a[23:15] == 9'h120)
            return RGN_TILE;
        if (a == ADDR_SOUND)
            return RGN_SOUND;
        return RGN_NONE;
    endfunction

    function automatic bit is_ram(input region_t rg);
        return rg == RGN_WORK || rg == RGN_SPRITE || rg == RGN_PAL || rg == RGN_TILE;
    endfunction

    // address bit 0 drops out of every RAM index
    function automatic int ram_key(input logic [23:0] a);
        region_t     rg;
        logic [14:0] idx;
        rg = region_of(a);
        case (rg)
            RGN_WORK:   idx = a[15:1];
            RGN_SPRITE: idx = {4'b0, a[11:1]};
            RGN_PAL:    idx = {2'b0, a[13:1]};
            default:    idx = {1'b0, a[14:1]};
        endcase
        return int'({13'b0, rg, idx});
    endfunction

    function automatic bit prot_hit(input logic [23:0] a);
        return model_variant && region_of(a) == RGN_WORK
            && a[15:0] >= PROT_OFF_FOUR && a[15:0] <= PROT_OFF_ZHI;
    endfunction

    function automatic bit reads_unwritten(input req_t r);
        if (r.req_type != REQ_READ || prot_hit(r.address))
            return 1'b0;
        if (!is_ram(region_of(r.address)))
            return 1'b0;
        return !ram_img.exists(ram_key(r.address));
    endfunction

    function automatic rsp_t predict_bus(input req_t r);
        rsp_t    o;
        region_t rg;
        int      k;
        o  = '0;
        rg = region_of(r.address);
        k  = ram_key(r.address);
        if (r.req_type == REQ_READ)
        begin
            case (rg)
                RGN_ROM:    o.read_data = r.rom_word;
                RGN_WORK, RGN_SPRITE, RGN_PAL, RGN_TILE:
                begin
                    if (prot_hit(r.address))
                        o.read_data = (r.address[15:0] == PROT_OFF_FOUR) ? PROT_VAL_FOUR : '0;
                    else if (ram_img.exists(k))
                        o.read_data = ram_img[k];
                end
                RGN_PLAYER: o.read_data = r.player_word;
                RGN_COIN:
                    o.read_data = {11'b0, model_variant ? 1'b0 : r.eeprom_data_out,
                                   r.coin_nibble};
                RGN_SOUND:  o.read_data = {8'h00, r.sound_status};
                default:    o.read_data = UNMAPPED_WORD;
            endcase
        end
        else
        begin
            case (rg)
                RGN_WORK, RGN_SPRITE, RGN_PAL, RGN_TILE:
                begin
                    ram_img[k] = r.write_data;
                    ram_addrs  = {ram_addrs, r.address};
                end
                RGN_LATCH:
                begin
                    ee_pins         = r.write_data[2:0];
                    bank_sel        = r.write_data[6];
                    o.eeprom_strobe = 1'b1;
                end
                RGN_SCROLL: scroll_reg = r.write_data[8:0] & SCROLL_MASK;
                RGN_SOUND:
                begin
                    o.sound_write_strobe = 1'b1;
                    o.sound_write_byte   = r.write_data[7:0];
                end
                default: ;
            endcase
        end
        o.eeprom_cs    = ee_pins[0];
        o.eeprom_clk   = ee_pins[1];
        o.eeprom_di    = ee_pins[2];
        o.sound_bank   = bank_sel;
        o.scroll_value = scroll_reg;
        return o;
    endfunction

    // mostly mapped traffic; RAM reads revisit words already written
    function automatic req_t make_random_req();
        req_t        r;
        int          p;
        logic [23:0] a;
        r.req_type        = 1'($urandom_range(0, 1));
        r.write_data      = 16'($urandom);
        r.rom_word        = 16'($urandom);
        r.eeprom_data_out = 1'($urandom_range(0, 1));
        r.sound_status    = 8'($urandom);
        r.player_word     = 16'($urandom);
        r.coin_nibble     = 4'($urandom);
        p = $urandom_range(0, 99);
        if (p < 8)
        begin
            a = 24'($urandom_range(0, 24'h0fffff));
        end
        else if (p < 30)
        begin
            r.req_type = REQ_WRITE;
            case ($urandom_range(0, 3))
                0:       a = 24'h100000 | 24'($urandom_range(0, 16'hffff));
                1:       a = 24'h500000 | 24'($urandom_range(0, 12'hfff));
                2:       a = 24'h800000 | 24'($urandom_range(0, 14'h3fff));
                default: a = 24'h900000 | 24'($urandom_range(0, 15'h7fff));
            endcase
        end
        else if (p < 55)
        begin
            r.req_type = REQ_READ;
            if (ram_addrs.size() == 0)
                a = 24'h100000;
            else
            begin
                a    = ram_addrs[$urandom_range(0, ram_addrs.size() - 1)];
                a[0] = 1'($urandom_range(0, 1));
            end
        end
        else if (p < 62)
        begin
            a = {8'h10, PROT_OFF_FOUR + 16'($urandom_range(0, 3))};
        end
        else if (p < 90)
        begin
            case ($urandom_range(0, 4))
                0:       a = ADDR_PLAYER;
                1:       a = ADDR_COIN;
                2:       a = ADDR_LATCH;
                3:       a = ADDR_SCROLL;
                default: a = ADDR_SOUND;
            endcase
        end
        else
        begin
            a = 24'($urandom);
        end
        r.address = a;
        if (reads_unwritten(r))
            r.req_type = REQ_WRITE;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        if (no_gaps)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic note_error(input string msg);
        $display("[%0t] ERROR %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            note_error($sformatf("%s: got %h, want %h", name, got, want));
    endtask

    // called right after clk rises; returns once the DUT has taken the request
    task automatic send_req(input req_t r);
        req   <= r;
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] a, output logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // variant changes only with no request in flight
    task automatic set_variant(input logic v);
        logic [31:0] rd;
        start <= 1'b0;
        while (bus_results_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        apb_write(CFG_ADDR_VARIANT, {31'b0, v});
        model_variant = v;
        @(posedge clk);
        apb_read(CFG_ADDR_VARIANT, rd);
        if (rd !== {31'b0, v})
            note_error($sformatf("variant readback: got %h, want %h", rd, {31'b0, v}));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (bus_results_due.size() == 0)
                note_error("result with no request pending");
            else
            begin
                want_rsp = bus_results_due.pop_front();
                check_field("read_data", rsp.read_data, want_rsp.read_data);
                check_field("eeprom_strobe", 16'(rsp.eeprom_strobe),
                            16'(want_rsp.eeprom_strobe));
                check_field("eeprom_di", 16'(rsp.eeprom_di), 16'(want_rsp.eeprom_di));
                check_field("eeprom_cs", 16'(rsp.eeprom_cs), 16'(want_rsp.eeprom_cs));
                check_field("eeprom_clk", 16'(rsp.eeprom_clk), 16'(want_rsp.eeprom_clk));
                check_field("sound_bank", 16'(rsp.sound_bank), 16'(want_rsp.sound_bank));
                check_field("sound_write_strobe", 16'(rsp.sound_write_strobe),
                            16'(want_rsp.sound_write_strobe));
                check_field("sound_write_byte", 16'(rsp.sound_write_byte),
                            16'(want_rsp.sound_write_byte));
                check_field("scroll_value", 16'(rsp.scroll_value),
                            16'(want_rsp.scroll_value));
            end
        end
    end

    initial
    begin
        int   cur_v;
        req_t r;
        rsp_t e;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_v = -1;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (int'(dir_tab[i].variant) != cur_v)
            begin
                set_variant(dir_tab[i].variant);
                cur_v = int'(dir_tab[i].variant);
            end
            r.req_type        = dir_tab[i].rt;
            r.address         = dir_tab[i].addr;
            r.write_data      = dir_tab[i].wdata;
            r.rom_word        = dir_tab[i].ext;
            r.player_word     = dir_tab[i].ext;
            r.sound_status    = dir_tab[i].ext[7:0];
            r.coin_nibble     = dir_tab[i].ext[3:0];
            r.eeprom_data_out = dir_tab[i].ext[4];
            send_req(r);
            e = predict_bus(r);
            if (dir_tab[i].lit_ok)
                e.read_data = dir_tab[i].lit;
            bus_results_due = {bus_results_due, e};
            idle_for(pick_gap());
        end

        // four phases: second game, first game, and back again
        for (int ph = 0; ph < 4; ph++)
        begin
            set_variant(ph[0] ? 1'b0 : 1'b1);
            for (int n = 0; n < 350; n++)
            begin
                if (n % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                r = make_random_req();
                send_req(r);
                e = predict_bus(r);
                bus_results_due = {bus_results_due, e};
                idle_for(pick_gap());
            end
        end
        no_gaps = 1'b0;

        start <= 1'b0;
        while (bus_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting for results");
        $display("Some tests failed");
        $finish;
    end

endmodule

/* board_memory_map_bus.f */
hdl/bmm_pkg.sv
hdl/bmm_ram.sv
hdl/bmm_decode.sv
hdl/board_memory_map_bus.sv
hdl/bmm_checker.sv
tb/tb_top.sv
